// File: design/pkct_pkg.sv
// ---------------------------------------------------------------------------
// pkct_pkg
// Shared constants, result codes and controller/datapath interface structs
// for the pair-keyed capture table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pkct_pkg;

    // field widths
    localparam int LEN_W    = 16;
    localparam int MAC_W    = 48;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 5;

    // table geometry and register defaults
    localparam int TABLE_SLOTS_DEFAULT = 16;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 16'd20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 16'd1;

    // one table entry: first key, second key, frame count
    localparam int ENTRY_W = 2 * MAC_W + COUNT_W;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_MIN_LEN = 1'b0;

    // item operation
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_SHORT  = 3'd0,
        ST_MATCH  = 3'd1,
        ST_INSERT = 3'd2,
        ST_FULL   = 3'd3,
        ST_CLEAR  = 3'd4
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    clear_table;
        logic    ptr_clear;
        logic    ptr_inc;
        logic    rd_en;
        logic    wr_insert;
        logic    wr_match;
        logic    set_result;
        status_t result_code;
        logic    load_out;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_clear;
        logic is_short;
        logic search_done;
        logic table_full;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: design/pkct_ram.sv
// ---------------------------------------------------------------------------
// pkct_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/pkct_ctrl.sv
// ---------------------------------------------------------------------------
// pkct_ctrl
// Sequencer for one item: dispatch, slot-by-slot search, update, and
// hand-off of the result beat to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkct_ctrl
    import pkct_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_COMPARE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.result_code = ST_SHORT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_clear)
                begin
                    cmd.clear_table = 1'b1;
                    cmd.set_result  = 1'b1;
                    cmd.result_code = ST_CLEAR;
                    state_next      = S_RESULT;
                end
                else if (stat.is_short)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = ST_SHORT;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.ptr_clear = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                // all occupied slots searched without a hit
                if (stat.search_done)
                begin
                    cmd.set_result = 1'b1;
                    if (stat.table_full)
                    begin
                        cmd.result_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_insert   = 1'b1;
                        cmd.result_code = ST_INSERT;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                if (stat.hit)
                begin
                    cmd.wr_match    = 1'b1;
                    cmd.set_result  = 1'b1;
                    cmd.result_code = ST_MATCH;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/pkct_dp.sv
// ---------------------------------------------------------------------------
// pkct_dp
// Datapath: input latch, entry table RAM, search pointer, occupancy count,
// key compare, saturating count update and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pkct_dp
    import pkct_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [LEN_W-1:0]   min_len,
    input  wire logic               op,
    input  wire logic [LEN_W-1:0]   frame_length,
    input  wire logic [MAC_W-1:0]   bssid_addr,
    input  wire logic [MAC_W-1:0]   client_addr,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [STATUS_W-1:0]     status,
    output logic [ID_W-1:0]         entry_id,
    output logic [COUNT_W-1:0]      frame_count,
    output logic [ID_W-1:0]         entries_used
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int XW = (CW > ID_W) ? CW : ID_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

    // latched item
    logic               op_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [MAC_W-1:0]   first_reg;
    logic [MAC_W-1:0]   second_reg;

    // search state
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      entry_count_reg;

    // pending result
    status_t            res_status_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [COUNT_W-1:0] res_count_reg;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [ID_W-1:0]    out_used_reg;

    // table ram signals
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [AW-1:0]      slot_idx;
    logic [MAC_W-1:0]   rd_first;
    logic [MAC_W-1:0]   rd_second;
    logic [COUNT_W-1:0] rd_count;
    logic [COUNT_W-1:0] count_new;
    logic [XW-1:0]      id_wide;
    logic [XW-1:0]      used_wide;

    assign slot_idx = ptr_reg[AW-1:0];
    assign rd_first  = ram_rdata[ENTRY_W-1 -: MAC_W];
    assign rd_second = ram_rdata[COUNT_W +: MAC_W];
    assign rd_count  = ram_rdata[COUNT_W-1:0];

    // saturating count increment
    assign count_new = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_ONE;

    // entry write: new pair or bumped count of a matched pair
    assign ram_we    = cmd.wr_insert | cmd.wr_match;
    assign ram_wdata = cmd.wr_match ? {rd_first, rd_second, count_new}
                                    : {first_reg, second_reg, COUNT_ONE};

    pkct_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (slot_idx),
        .rdata (ram_rdata)
    );

    // id is slot plus one, masked to the port width
    assign id_wide   = XW'(ptr_reg) + XW'(1);
    assign used_wide = XW'(entry_count_reg);

    // status toward the controller
    always_comb
    begin
        stat.is_clear    = (op_reg == OP_CLEAR);
        stat.is_short    = (len_reg < min_len);
        stat.search_done = (ptr_reg == entry_count_reg);
        stat.table_full  = (entry_count_reg == SLOTS_C);
        stat.hit         = (rd_first == first_reg) && (rd_second == second_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // input latch and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= op;
            len_reg    <= frame_length;
            first_reg  <= bssid_addr;
            second_reg <= client_addr;
        end
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.result_code;
            if (cmd.wr_match)
            begin
                res_id_reg    <= id_wide[ID_W-1:0];
                res_count_reg <= count_new;
            end
            else if (cmd.wr_insert)
            begin
                res_id_reg    <= id_wide[ID_W-1:0];
                res_count_reg <= COUNT_ONE;
            end
            else
            begin
                res_id_reg    <= '0;
                res_count_reg <= '0;
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_count_reg  <= res_count_reg;
            out_used_reg   <= used_wide[ID_W-1:0];
        end
    end

    // search pointer and occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            if (cmd.ptr_clear)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + CW'(1);
            end
            if (cmd.clear_table)
            begin
                entry_count_reg <= '0;
            end
            else if (cmd.wr_insert)
            begin
                entry_count_reg <= entry_count_reg + CW'(1);
            end
        end
    end

    // output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign entry_id     = out_id_reg;
    assign frame_count  = out_count_reg;
    assign entries_used = out_used_reg;

endmodule

`default_nettype wire

// File: design/pair_keyed_capture_table.sv
// ---------------------------------------------------------------------------
// pair_keyed_capture_table
// Table of address pairs with saturating per-pair frame counts.
// ---------------------------------------------------------------------------
// Each input beat is either a frame (length plus two 48-bit addresses) or a
// table clear, and yields exactly one result beat. Clears and short frames go
// from dispatch straight to the result state; a frame reads the occupied
// slots of the entry RAM in order, one per read state, compares each in the
// compare state and ends at the first hit (match) or, past the last occupied
// slot, inserts the pair or drops it when the table is full. The controller
// returns to idle before the next beat is taken. The next input beat is
// accepted while a finished result still waits in the output register.
// min_frame_length sits at byte address 0 of the APB port and resets to 20.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pair_keyed_capture_table
    import pkct_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // item channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  op,
    input  wire logic [LEN_W-1:0]      frame_length,
    input  wire logic [MAC_W-1:0]      bssid_addr,
    input  wire logic [MAC_W-1:0]      client_addr,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [ID_W-1:0]            entry_id,
    output logic [COUNT_W-1:0]         frame_count,
    output logic [ID_W-1:0]            entries_used,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    cmd_t             cmd;
    stat_t            stat;
    logic [LEN_W-1:0] min_len_reg;
    logic             reg_sel;
    logic             cfg_wr;

    // register index from the word address
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && (reg_sel == REG_MIN_LEN);
    assign pready  = 1'b1;

    // minimum frame length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            min_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // register readback
    assign prdata = (reg_sel == REG_MIN_LEN) ? APB_DATA_W'(min_len_reg) : '0;

    pkct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pkct_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .min_len      (min_len_reg),
        .op           (op),
        .frame_length (frame_length),
        .bssid_addr   (bssid_addr),
        .client_addr  (client_addr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_id     (entry_id),
        .frame_count  (frame_count),
        .entries_used (entries_used)
    );

endmodule

`default_nettype wire

// File: bench/capture_table_checker.sv
// ---------------------------------------------------------------------------
// capture_table_checker
// Watches the item, result and configuration channels of the pair-keyed
// capture table. Keeps its own copy of the pair table and the minimum
// length. Predicts one result per accepted item and compares every result
// beat, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module capture_table_checker
    import pkct_pkg::*;
#(
    parameter int SLOTS = TABLE_SLOTS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic                  op,
    input  wire logic [LEN_W-1:0]      frame_length,
    input  wire logic [MAC_W-1:0]      bssid_addr,
    input  wire logic [MAC_W-1:0]      client_addr,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [STATUS_W-1:0]   status,
    input  wire logic [ID_W-1:0]       entry_id,
    input  wire logic [COUNT_W-1:0]    frame_count,
    input  wire logic [ID_W-1:0]       entries_used,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         errors,
    output int                         pending
);

    typedef struct packed {
        status_t            st;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] cnt;
        logic [ID_W-1:0]    used;
    } table_result_t;

    // shadow of the pair table
    logic [MAC_W-1:0]   shadow_first [SLOTS];
    logic [MAC_W-1:0]   shadow_second[SLOTS];
    logic [COUNT_W-1:0] shadow_count [SLOTS];
    int                 used_slots;
    logic [LEN_W-1:0]   min_len;

    table_result_t      expected_results[$];
    int                 fail_cnt = 0;

    initial begin
        errors  = 0;
        pending = 0;
    end

    // search, count and insert for one item beat
    function automatic table_result_t lookup_and_count(
        input logic             opv,
        input logic [LEN_W-1:0] len,
        input logic [MAC_W-1:0] first,
        input logic [MAC_W-1:0] second
    );
        table_result_t r;
        int            hit_slot;
        r.st     = ST_SHORT;
        r.id     = '0;
        r.cnt    = '0;
        hit_slot = -1;
        if (opv == OP_CLEAR) begin
            used_slots = 0;
            r.st = ST_CLEAR;
        end else if (len < min_len) begin
            r.st = ST_SHORT;
        end else begin
            // first occupied slot holding the pair wins
            for (int s = 0; s < used_slots && s < SLOTS; s++) begin
                if (hit_slot < 0 && shadow_first[s] == first && shadow_second[s] == second)
                    hit_slot = s;
            end
            if (hit_slot >= 0) begin
                if (shadow_count[hit_slot] != COUNT_MAX)
                    shadow_count[hit_slot] = shadow_count[hit_slot] + 1'b1;
                r.st  = ST_MATCH;
                r.id  = ID_W'(hit_slot + 1);
                r.cnt = shadow_count[hit_slot];
            end else if (used_slots < SLOTS) begin
                shadow_first[used_slots]  = first;
                shadow_second[used_slots] = second;
                shadow_count[used_slots]  = COUNT_ONE;
                used_slots = used_slots + 1;
                r.st  = ST_INSERT;
                r.id  = ID_W'(used_slots);
                r.cnt = COUNT_ONE;
            end else begin
                r.st = ST_FULL;
            end
        end
        r.used = ID_W'(used_slots);
        return r;
    endfunction

    task automatic check_field(
        input string       name,
        input logic [15:0] want_v,
        input logic [15:0] got_v
    );
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // result beats first, then configuration, then new item beats
    always @(posedge clk or negedge rst_n) begin
        table_result_t want;
        if (!rst_n) begin
            used_slots = 0;
            min_len    = MIN_LEN_RESET;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %0d id %0d",
                             $time, status, entry_id);
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 16'(want.st), 16'(status));
                    check_field("entry_id", 16'(want.id), 16'(entry_id));
                    check_field("frame_count", want.cnt, frame_count);
                    check_field("entries_used", 16'(want.used), 16'(entries_used));
                end
            end
            // register index is the word address
            if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_LEN)
                min_len = pwdata[LEN_W-1:0];
            if (in_valid && in_ready)
                expected_results.push_back(
                    lookup_and_count(op, frame_length, bssid_addr, client_addr));
            pending <= expected_results.size();
            errors  <= fail_cnt;
        end
    end

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the pair-keyed capture table. Runs a directed
// pass over the field extremes, table fill, drop, match and clear, then
// random phases over several minimum lengths and idle patterns, then a
// run on one pair that keeps raising its count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pkct_pkg::*;

    localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR  = {REG_MIN_LEN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
    localparam logic [MAC_W-1:0]      MAC_ONES      = '1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int POOL_MAX       = 24;
    localparam int PHASE_ITEMS    = 170;
    localparam int PAIR_FRAMES    = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic [LEN_W-1:0]      frame_length;
    logic [MAC_W-1:0]      bssid_addr;
    logic [MAC_W-1:0]      client_addr;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       entry_id;
    logic [COUNT_W-1:0]    frame_count;
    logic [ID_W-1:0]       entries_used;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int snd_idle  = 0;
    int rcv_stall = 0;
    bit valid_up  = 1'b0;
    logic [LEN_W-1:0] cur_min;

    // address pairs that random frames revisit
    logic [MAC_W-1:0] pool_first [POOL_MAX];
    logic [MAC_W-1:0] pool_second[POOL_MAX];
    int               pool_n;

    always #10 clk = ~clk;

    pair_keyed_capture_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .frame_length (frame_length),
        .bssid_addr   (bssid_addr),
        .client_addr  (client_addr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_id     (entry_id),
        .frame_count  (frame_count),
        .entries_used (entries_used),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    capture_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .frame_length (frame_length),
        .bssid_addr   (bssid_addr),
        .client_addr  (client_addr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_id     (entry_id),
        .frame_count  (frame_count),
        .entries_used (entries_used),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .pending      (pending)
    );

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_stall);

    // ends the run when no beat moves for too long
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom(), $urandom()});
    endfunction

    // present one item beat and hold it until accepted, then maybe go idle
    task automatic send_beat(
        input logic             opv,
        input logic [LEN_W-1:0] len,
        input logic [MAC_W-1:0] first,
        input logic [MAC_W-1:0] second
    );
        in_valid     <= 1'b1;
        valid_up     = 1'b1;
        op           <= opv;
        frame_length <= len;
        bssid_addr   <= first;
        client_addr  <= second;
        do @(posedge clk); while (!in_ready);
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle);
        end
    endtask

    // stop sending and wait until every result has come back
    task automatic settle();
        if (valid_up) begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(
        input logic [APB_ADDR_W-1:0] addr,
        input logic [APB_DATA_W-1:0] data
    );
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int               p;
        int               i;
        int               r;
        int               c;
        int               k;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] m;
        logic [MAC_W-1:0] a;
        logic [MAC_W-1:0] b;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_FRAME;
        frame_length = '0;
        bssid_addr   = '0;
        client_addr  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_min      = MIN_LEN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write outside the register map leaves the minimum at its reset value
        apb_write(UNMAPPED_ADDR, 32'h0000_0000);

        // directed: clear on empty, short frames, extremes, match, fill, drop
        send_beat(OP_CLEAR, 16'h0000, '0, '0);
        send_beat(OP_FRAME, 16'd0, MAC_ONES, MAC_ONES);
        send_beat(OP_FRAME, 16'd19, '0, '0);
        send_beat(OP_FRAME, 16'd20, '0, '0);
        send_beat(OP_FRAME, 16'hFFFF, MAC_ONES, MAC_ONES);
        send_beat(OP_FRAME, 16'd20, '0, '0);
        send_beat(OP_FRAME, 16'd21, '0, MAC_ONES);
        send_beat(OP_FRAME, 16'd21, MAC_ONES, '0);
        for (i = 0; i < 12; i++)
            send_beat(OP_FRAME, 16'd64, 48'hA55A_0000_0000 | i, 48'h5AA5_0000_0000 | (i << 8));
        send_beat(OP_FRAME, 16'd64, 48'h1234_5678_9ABC, 48'hCBA9_8765_4321);
        send_beat(OP_FRAME, 16'd64, 48'hA55A_0000_000B, 48'h5AA5_0000_0B00);
        send_beat(OP_CLEAR, 16'hFFFF, MAC_ONES, MAC_ONES);
        send_beat(OP_FRAME, 16'd20, '0, '0);
        settle();

        // random phases over minimum lengths and idle patterns
        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 83; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 83; end
                default: begin snd_idle = 37; rcv_stall = 37; end
            endcase
            case (p)
                0: m = 16'd0;
                1: m = 16'hFFFF;
                2: m = 16'd64;
                4: m = 16'd20;
                5: m = 16'd1500;
                7: m = 16'd1;
                default: m = LEN_W'($urandom_range(65535));
            endcase
            apb_write(MIN_LEN_ADDR, APB_DATA_W'(m));
            cur_min = m;

            // pool size above and below the table size; many clients per access point
            pool_n = $urandom_range(POOL_MAX, 10);
            for (k = 0; k < POOL_MAX; k++) begin
                pool_first[k]  = ($urandom_range(1)) ? pool_first[0] : rand_mac();
                pool_second[k] = rand_mac();
                if (k == 0)
                    pool_first[k] = rand_mac();
            end

            for (i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(99);
                c = $urandom_range(99);
                if (r < 10)
                    len = LEN_W'($urandom_range(65535));
                else if (r < 20 && cur_min > 0)
                    len = LEN_W'($urandom_range(cur_min - 1, 0));
                else if (r < 30)
                    len = cur_min;
                else
                    len = LEN_W'($urandom_range(65535, cur_min));
                k = $urandom_range(pool_n - 1);
                if (c < 72) begin
                    a = pool_first[k];
                    b = pool_second[k];
                end else if (c < 80) begin
                    a = pool_first[k];
                    b = rand_mac();
                end else if (c < 88) begin
                    a = pool_first[k];
                    b = pool_second[$urandom_range(pool_n - 1)];
                end else begin
                    a = rand_mac();
                    b = rand_mac();
                end
                if ($urandom_range(99) < 3)
                    send_beat(OP_CLEAR, len, a, b);
                else
                    send_beat(OP_FRAME, len, a, b);
            end
            settle();
        end

        // one pair hit over and over
        snd_idle  = 0;
        rcv_stall = 0;
        apb_write(MIN_LEN_ADDR, APB_DATA_W'(MIN_LEN_RESET));
        cur_min = MIN_LEN_RESET;
        a = rand_mac();
        b = rand_mac();
        send_beat(OP_CLEAR, 16'd0, '0, '0);
        for (i = 0; i < PAIR_FRAMES; i++)
            send_beat(OP_FRAME, 16'hFFFF, a, b);
        settle();

        repeat (64) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
